// ===== rtl/core/lru_page_table_unit_defines.svh =====
// assertion macros for the lru page table unit
`ifndef LRU_PAGE_TABLE_UNIT_DEFINES_SVH
`define LRU_PAGE_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpt assertion failed");
`define LPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpt assertion failed");
`else
`define LPT_ASSERT_IMP(lbl, ante, cons)
`define LPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/lpt_pkg.sv =====
// shared widths, register indexes and page status codes of the lru page table
package lpt_pkg;

  localparam int VA_W       = 32;
  localparam int PA_W       = 16;
  localparam int EVP_W      = 6;
  localparam int CNT_W      = 32;
  localparam int NP_W       = 7;
  localparam int NF_W       = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           page_st_t;

  localparam cfg_idx_t REG_NUM_PAGES  = 4'd0;
  localparam cfg_idx_t REG_NUM_FRAMES = 4'd1;

  localparam page_st_t ST_EMPTY  = 2'd0;
  localparam page_st_t ST_LOADED = 2'd1;
  localparam page_st_t ST_DIRTY  = 2'd2;

  localparam logic [NP_W-1:0] NUM_PAGES_RST  = 7'd64;
  localparam logic [NF_W-1:0] NUM_FRAMES_RST = 5'd16;

endpackage

// ===== rtl/core/lpt_if.sv =====
// channel interfaces of the lru page table: reference, translation and config write

interface lpt_req_if;
  logic                     valid;
  logic                     ready;
  logic [lpt_pkg::VA_W-1:0] virtual_address;
  logic                     is_write;
  modport source (output valid, virtual_address, is_write, input ready);
  modport sink (input valid, virtual_address, is_write, output ready);
endinterface

interface lpt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lpt_pkg::PA_W-1:0]  physical_address;
  logic                      invalid;
  logic                      page_fault;
  logic                      evicted;
  logic                      writeback;
  logic [lpt_pkg::EVP_W-1:0] evicted_page;
  logic [lpt_pkg::CNT_W-1:0] load_count;
  logic [lpt_pkg::CNT_W-1:0] save_count;
  logic [lpt_pkg::CNT_W-1:0] replace_count;
  modport source (output valid, physical_address, invalid, page_fault, evicted, writeback,
                  evicted_page, load_count, save_count, replace_count, input ready);
  modport sink (input valid, physical_address, invalid, page_fault, evicted, writeback,
                evicted_page, load_count, save_count, replace_count, output ready);
endinterface

interface lpt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpt_pkg::CFG_IDX_W-1:0]  index;
  logic [lpt_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lru_page_table_unit.sv =====
// lru page table: translates references, loads faulting pages, evicts least recently used
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------------
//  req     | in  | virtual_address, is_write
//  rsp     | out | physical_address, flags, evicted_page, load/save/replace counts
//  cfg     | in  | index, data (0 = num_pages, 1 = num_frames); always ready
//
// one word at a time: an invalid reference goes straight to rsp, a hit renews its frame
// timestamp, a fault loads a free frame or, with the active frames all in use, evicts; the eviction
// scan reads one frame timestamp per cycle from the shared timestamp memory.
// after reset a clear pass empties every page table entry; req is not
// ready meanwhile. a result waiting on rsp holds off the next req word.

`include "lru_page_table_unit_defines.svh"

module lru_page_table_unit #(
  parameter int NUM_PAGES  = 64,
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 12
) (
  input logic       clk,
  input logic       rst,
  lpt_req_if.sink   req,
  lpt_rsp_if.source rsp,
  lpt_cfg_if.sink   cfg
);

  localparam int PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PCW = $clog2(NUM_PAGES + 1);
  localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int VPW = lpt_pkg::VA_W - PAGE_BITS;
  localparam int EW  = FW + 2;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOOK = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_OWN  = 4'd4;
  localparam logic [3:0] S_VRD  = 4'd5;
  localparam logic [3:0] S_VUPD = 4'd6;
  localparam logic [3:0] S_LOAD = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state;

  logic [lpt_pkg::NP_W-1:0] num_pages;
  logic [lpt_pkg::NF_W-1:0] num_frames;

  // page table entry: {status, frame}
  logic [EW-1:0] pmem [NUM_PAGES];
  logic [EW-1:0] pmem_q;
  logic [31:0]   ftime [NUM_FRAMES];
  logic [31:0]   ftime_q;
  logic [PW-1:0] fowner [NUM_FRAMES];
  logic [PW-1:0] fowner_q;

  logic [PCW-1:0]       clr_idx;
  logic [PW-1:0]        page_reg;
  logic [PAGE_BITS-1:0] offset_reg;
  logic                 wr_reg;
  logic [CW-1:0]        frames_used;
  logic [FW-1:0]        frame_sel;
  logic [CW-1:0]        scan_idx;
  logic                 cmp_vld;
  logic [FW-1:0]        cmp_idx;
  logic [FW-1:0]        best;
  logic [31:0]          best_t;
  logic [31:0]          acc_time;
  logic [31:0]          load_total;
  logic [31:0]          save_total;
  logic [31:0]          replace_total;

  logic [lpt_pkg::PA_W-1:0]  res_paddr;
  logic                      res_invalid;
  logic                      res_fault;
  logic                      res_evict;
  logic                      res_wb;
  logic [lpt_pkg::EVP_W-1:0] res_victim;

  logic [VPW-1:0]          req_page;
  logic [PCW-1:0]          lim_pages;
  logic [CW-1:0]           lim_frames;
  logic                    req_inv;
  logic                    req_acc;
  lpt_pkg::page_st_t       look_st;
  logic [FW-1:0]           look_frame;
  logic                    look_hit;
  logic [PW-1:0]           pm_raddr;
  logic                    pm_we;
  logic [PW-1:0]           pm_waddr;
  logic [EW-1:0]           pm_wdata;
  logic                    ft_we;
  logic [FW-1:0]           ft_waddr;
  logic [31:0]             acc_time_next;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (&v) ? v : v + 32'd1;
  endfunction

  assign req_page = req.virtual_address[lpt_pkg::VA_W-1:PAGE_BITS];

  always_comb begin
    if (32'(num_pages) > NUM_PAGES) begin
      lim_pages = PCW'(NUM_PAGES);
    end else begin
      lim_pages = PCW'(num_pages);
    end
    if (num_frames == '0) begin
      lim_frames = CW'(1);
    end else if (32'(num_frames) > NUM_FRAMES) begin
      lim_frames = CW'(NUM_FRAMES);
    end else begin
      lim_frames = CW'(num_frames);
    end
  end

  assign req_inv  = 32'(req_page) >= 32'(lim_pages);
  assign req_acc  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign look_st    = pmem_q[EW-1:FW];
  assign look_frame = pmem_q[FW-1:0];
  assign look_hit   = (look_st != lpt_pkg::ST_EMPTY);
  assign acc_time_next = sat_inc(acc_time);

  // page table port control
  always_comb begin
    pm_raddr = fowner_q;
    if (state == S_IDLE) begin
      pm_raddr = req_page[PW-1:0];
    end
    pm_we    = 1'b0;
    pm_waddr = page_reg;
    pm_wdata = {lpt_pkg::ST_EMPTY, FW'(0)};
    case (state)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_idx[PW-1:0];
      end
      S_LOOK: begin
        pm_we    = look_hit;
        pm_wdata = {(wr_reg ? lpt_pkg::ST_DIRTY : look_st), look_frame};
      end
      S_VUPD: begin
        pm_we    = 1'b1;
        pm_waddr = fowner_q;
      end
      S_LOAD: begin
        pm_we    = 1'b1;
        pm_wdata = {(wr_reg ? lpt_pkg::ST_DIRTY : lpt_pkg::ST_LOADED), frame_sel};
      end
      default: begin
        pm_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ft_we    = 1'b0;
    ft_waddr = frame_sel;
    if (state == S_LOOK && look_hit) begin
      ft_we    = 1'b1;
      ft_waddr = look_frame;
    end else if (state == S_LOAD) begin
      ft_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pmem_q <= pmem[pm_raddr];
    if (pm_we) begin
      pmem[pm_waddr] <= pm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ftime_q <= ftime[scan_idx[FW-1:0]];
    if (ft_we) begin
      ftime[ft_waddr] <= acc_time;
    end
  end

  always_ff @(posedge clk) begin
    fowner_q <= fowner[best];
    if (state == S_LOAD) begin
      fowner[frame_sel] <= page_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pages  <= lpt_pkg::NUM_PAGES_RST;
      num_frames <= lpt_pkg::NUM_FRAMES_RST;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == lpt_pkg::REG_NUM_PAGES) begin
        num_pages <= cfg.data[lpt_pkg::NP_W-1:0];
      end else if (cfg.index == lpt_pkg::REG_NUM_FRAMES) begin
        num_frames <= cfg.data[lpt_pkg::NF_W-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      frames_used   <= '0;
      acc_time      <= '0;
      load_total    <= '0;
      save_total    <= '0;
      replace_total <= '0;
      cmp_vld       <= 1'b0;
      scan_idx      <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + PCW'(1);
          if (32'(clr_idx) == NUM_PAGES - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            page_reg    <= req_page[PW-1:0];
            offset_reg  <= req.virtual_address[PAGE_BITS-1:0];
            wr_reg      <= req.is_write;
            res_paddr   <= '0;
            res_invalid <= req_inv;
            res_fault   <= 1'b0;
            res_evict   <= 1'b0;
            res_wb      <= 1'b0;
            res_victim  <= '0;
            state       <= req_inv ? S_OUT : S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_hit) begin
            acc_time  <= acc_time_next;
            res_paddr <= lpt_pkg::PA_W'((32'(look_frame) << PAGE_BITS) | 32'(offset_reg));
            state     <= S_OUT;
          end else if (frames_used < lim_frames) begin
            frame_sel   <= frames_used[FW-1:0];
            frames_used <= frames_used + CW'(1);
            state       <= S_LOAD;
          end else begin
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // the timestamp read is registered, so its compare follows in the next cycle
          if (scan_idx < lim_frames) begin
            scan_idx <= scan_idx + CW'(1);
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[FW-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (cmp_idx == '0 || ftime_q < best_t) begin
              best   <= cmp_idx;
              best_t <= ftime_q;
            end
            if (CW'(cmp_idx) == lim_frames - CW'(1)) begin
              cmp_vld <= 1'b0;
              state   <= S_OWN;
            end
          end
        end
        S_OWN: begin
          frame_sel <= best;
          state     <= S_VRD;
        end
        S_VRD: begin
          state <= S_VUPD;
        end
        S_VUPD: begin
          res_evict     <= 1'b1;
          res_victim    <= lpt_pkg::EVP_W'(fowner_q);
          replace_total <= sat_inc(replace_total);
          if (look_st == lpt_pkg::ST_DIRTY) begin
            res_wb     <= 1'b1;
            save_total <= sat_inc(save_total);
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          res_fault  <= 1'b1;
          load_total <= sat_inc(load_total);
          acc_time   <= acc_time_next;
          res_paddr  <= lpt_pkg::PA_W'((32'(frame_sel) << PAGE_BITS) | 32'(offset_reg));
          state      <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = (state == S_OUT);
  assign rsp.physical_address = res_paddr;
  assign rsp.invalid          = res_invalid;
  assign rsp.page_fault       = res_fault;
  assign rsp.evicted          = res_evict;
  assign rsp.writeback        = res_wb;
  assign rsp.evicted_page     = res_victim;
  assign rsp.load_count       = load_total;
  assign rsp.save_count       = save_total;
  assign rsp.replace_count    = replace_total;

  `LPT_ASSERT_NXT(a_inv_direct, req_acc && req_inv, rsp.valid && rsp.invalid)
  `LPT_ASSERT_IMP(a_evict_is_fault, rsp.valid && rsp.evicted, rsp.page_fault && !rsp.invalid)
  `LPT_ASSERT_IMP(a_wb_needs_evict, rsp.valid && rsp.writeback, rsp.evicted)
  `LPT_ASSERT_IMP(a_frames_bound, state != S_CLR, 32'(frames_used) <= NUM_FRAMES)

endmodule

// ===== tb/lpt_translation_checker.sv =====
// checker for the lru page table: predicts each translation and compares the response words
module lpt_translation_checker #(
  parameter int NUM_PAGES  = 64,
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 12
) (
  input  logic clk,
  input  logic rst,
  lpt_req_if   req,
  lpt_rsp_if   rsp,
  lpt_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   faults,
  output int   evictions,
  output int   writebacks,
  output int   invalids
);
  timeunit 1ns;
  timeprecision 1ps;

  import lpt_pkg::*;

  localparam int VPN_W   = VA_W - PAGE_BITS;
  localparam int FRAME_W = $clog2(NUM_FRAMES);

  typedef struct packed {
    logic [PA_W-1:0]  physical_address;
    logic             invalid;
    logic             page_fault;
    logic             evicted;
    logic             writeback;
    logic [EVP_W-1:0] evicted_page;
    logic [CNT_W-1:0] load_count;
    logic [CNT_W-1:0] save_count;
    logic [CNT_W-1:0] replace_count;
  } xlat_t;

  page_st_t           pg_state [NUM_PAGES];
  logic [FRAME_W-1:0] pg_frame [NUM_PAGES];
  logic [CNT_W-1:0]   pg_stamp [NUM_PAGES];
  logic [EVP_W-1:0]   frm_page [NUM_FRAMES];
  int unsigned        frames_filled;
  logic [CNT_W-1:0]   clock_now;
  logic [CNT_W-1:0]   loads;
  logic [CNT_W-1:0]   saves;
  logic [CNT_W-1:0]   replaces;
  logic [NP_W-1:0]    cfg_pages;
  logic [NF_W-1:0]    cfg_frames;
  xlat_t              xlat_q [$];

  function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic xlat_t translate(input logic [VA_W-1:0] va, input logic wr);
    xlat_t            r;
    logic [VPN_W-1:0] vpn;
    int unsigned      active_pages;
    int unsigned      active_frames;
    int unsigned      p;
    int unsigned      frame;
    int unsigned      victim;
    int unsigned      old;
    r = '0;
    vpn = va[VA_W-1:PAGE_BITS];
    active_pages = (cfg_pages > NUM_PAGES) ? NUM_PAGES : 32'(cfg_pages);
    active_frames = (cfg_frames == 0) ? 1 :
                    ((cfg_frames > NUM_FRAMES) ? NUM_FRAMES : 32'(cfg_frames));
    if (32'(vpn) >= active_pages) begin
      r.invalid = 1'b1;
    end else begin
      p = 32'(vpn);
      if (pg_state[p] != ST_EMPTY) begin
        if (wr) pg_state[p] = ST_DIRTY;
      end else begin
        r.page_fault = 1'b1;
        if (frames_filled < active_frames) begin
          frame = frames_filled;
          frames_filled++;
        end else begin
          // oldest stamp among the active frames, lowest frame wins a tie
          victim = 0;
          for (int i = 1; i < active_frames; i++) begin
            if (pg_stamp[frm_page[i]] < pg_stamp[frm_page[victim]]) victim = i;
          end
          frame = victim;
          old = 32'(frm_page[victim]);
          r.evicted = 1'b1;
          r.evicted_page = EVP_W'(old);
          replaces = sat_up(replaces);
          if (pg_state[old] == ST_DIRTY) begin
            r.writeback = 1'b1;
            saves = sat_up(saves);
          end
          pg_state[old] = ST_EMPTY;
        end
        loads = sat_up(loads);
        pg_frame[p] = FRAME_W'(frame);
        pg_state[p] = wr ? ST_DIRTY : ST_LOADED;
        frm_page[frame] = EVP_W'(p);
      end
      pg_stamp[p] = clock_now;
      clock_now = sat_up(clock_now);
      r.physical_address = PA_W'({pg_frame[p], va[PAGE_BITS-1:0]});
    end
    r.load_count = loads;
    r.save_count = saves;
    r.replace_count = replaces;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_word(input xlat_t e);
    check_field("physical_address", 32'(e.physical_address), 32'(rsp.physical_address));
    check_field("invalid", 32'(e.invalid), 32'(rsp.invalid));
    check_field("page_fault", 32'(e.page_fault), 32'(rsp.page_fault));
    check_field("evicted", 32'(e.evicted), 32'(rsp.evicted));
    check_field("writeback", 32'(e.writeback), 32'(rsp.writeback));
    check_field("evicted_page", 32'(e.evicted_page), 32'(rsp.evicted_page));
    check_field("load_count", e.load_count, rsp.load_count);
    check_field("save_count", e.save_count, rsp.save_count);
    check_field("replace_count", e.replace_count, rsp.replace_count);
  endtask

  always @(posedge clk) begin
    xlat_t e;
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        pg_state[i] = ST_EMPTY;
        pg_frame[i] = '0;
        pg_stamp[i] = '0;
      end
      for (int i = 0; i < NUM_FRAMES; i++) frm_page[i] = '0;
      frames_filled = 0;
      clock_now = '0;
      loads = '0;
      saves = '0;
      replaces = '0;
      cfg_pages = NUM_PAGES_RST;
      cfg_frames = NUM_FRAMES_RST;
      xlat_q.delete();
      fail_count = 0;
      faults = 0;
      evictions = 0;
      writebacks = 0;
      invalids = 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_NUM_PAGES) cfg_pages = cfg.data[NP_W-1:0];
        else if (cfg.index == REG_NUM_FRAMES) cfg_frames = cfg.data[NF_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        if (xlat_q.size() == 0) begin
          $error("translation word with no reference outstanding");
          fail_count++;
        end else begin
          compare_word(xlat_q.pop_front());
        end
      end
      if (req.valid && req.ready) begin
        e = translate(req.virtual_address, req.is_write);
        faults += int'(e.page_fault);
        evictions += int'(e.evicted);
        writebacks += int'(e.writeback);
        invalids += int'(e.invalid);
        xlat_q.push_back(e);
      end
      pending <= xlat_q.size();
    end
  end

endmodule

// ===== tb/tb_lru_page_table_unit.sv =====
// top of the lru page table testbench: clock, reset, reference stimulus and verdict
module tb_lru_page_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lpt_pkg::*;

  localparam int NUM_PAGES    = 64;
  localparam int NUM_FRAMES   = 16;
  localparam int PAGE_BITS    = 12;
  localparam int VPN_W        = VA_W - PAGE_BITS;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 2 * NUM_FRAMES + 16;

  // index that maps to no register, written to show it is ignored
  localparam cfg_idx_t REG_SPARE = 4'hF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpt_req_if req ();
  lpt_rsp_if rsp ();
  lpt_cfg_if cfg ();

  int          fail_count;
  int          pending;
  int          faults;
  int          evictions;
  int          writebacks;
  int          invalids;
  int unsigned send_pct;
  int unsigned stall_pct;
  int unsigned act_pages;
  int unsigned act_frames;
  int          refs_sent;
  int          settings_used;

  lru_page_table_unit #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  lpt_translation_checker #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .fail_count(fail_count),
    .pending   (pending),
    .faults    (faults),
    .evictions (evictions),
    .writebacks(writebacks),
    .invalids  (invalids)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_ref(input logic [VA_W-1:0] va, input logic wr);
    while ($urandom_range(99) < send_pct) begin
      req.valid <= 1'b0;
      req.virtual_address <= $urandom();
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.virtual_address <= va;
    req.is_write <= wr;
    do @(posedge clk); while (!req.ready);
    refs_sent++;
  endtask

  // hold off references until every translation has come back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value, input int unsigned bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << bits) - 1'b1;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= (value & mask) | ($urandom() & ~mask);
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic apply_setting(input int unsigned pages, input int unsigned frames);
    drain();
    write_reg(REG_NUM_PAGES, pages, NP_W);
    write_reg(REG_NUM_FRAMES, frames, NF_W);
    write_reg(REG_SPARE, $urandom(), 0);
    cfg.valid <= 1'b0;
    act_pages = (pages > NUM_PAGES) ? NUM_PAGES : pages;
    act_frames = (frames == 0) ? 1 : ((frames > NUM_FRAMES) ? NUM_FRAMES : frames);
    settings_used++;
  endtask

  task automatic random_ref();
    logic [VPN_W-1:0] vpn;
    int unsigned      span;
    int unsigned      pick;
    pick = $urandom_range(99);
    // a working set a little larger than the frames keeps evictions coming
    span = act_frames + $urandom_range(4, 1);
    if (span > act_pages) span = act_pages;
    if (act_pages == 0 || pick < 8) vpn = VPN_W'($urandom_range(2 ** VPN_W - 1, act_pages));
    else if (pick < 80) vpn = VPN_W'($urandom_range(span - 1, 0));
    else vpn = VPN_W'($urandom_range(act_pages - 1, 0));
    send_ref({vpn, PAGE_BITS'($urandom())}, 1'($urandom()));
  endtask

  task automatic run_phase(input int unsigned pages, input int unsigned frames, input int n,
                           input idle_mode_t mode);
    apply_setting(pages, frames);
    case (mode)
      IDLE_NONE: begin
        send_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        send_pct = 74;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        send_pct = 0;
        stall_pct = 74;
      end
      default: begin
        send_pct = 28;
        stall_pct = 28;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      random_ref();
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.virtual_address = '0;
    req.is_write = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_NUM_PAGES;
    cfg.data = '0;
    send_pct = 0;
    stall_pct = 0;
    act_pages = NUM_PAGES;
    act_frames = NUM_FRAMES;
    refs_sent = 0;
    settings_used = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: first fault, far invalid, top page, hits, limit boundary, fill, evictions
    send_ref(32'h0000_0000, 1'b0);
    send_ref(32'hFFFF_FFFF, 1'b1);
    send_ref(32'h0003_FFFF, 1'b1);
    send_ref(32'h0003_F000, 1'b0);
    send_ref(32'h0000_0ABC, 1'b1);
    send_ref(32'h0004_0000, 1'b0);
    for (int p = 1; p <= 14; p++) send_ref({VPN_W'(p), 12'h555}, 1'b0);
    send_ref({VPN_W'(20), 12'h001}, 1'b0);
    send_ref({VPN_W'(21), 12'hFFE}, 1'b1);
    send_ref({VPN_W'(22), 12'h800}, 1'b0);

    // frames lowered, then pages lowered while pages stay resident
    run_phase(64, 16, 200, IDLE_NONE);
    run_phase(64, 3, 150, IDLE_SEND);
    run_phase(10, 3, 150, IDLE_RECV);
    run_phase(127, 31, 150, IDLE_BOTH);
    run_phase(1, 1, 100, IDLE_NONE);
    run_phase(0, 0, 40, IDLE_SEND);
    run_phase(64, 1, 100, IDLE_RECV);
    run_phase(40, 16, 200, IDLE_BOTH);
    repeat (4) begin
      run_phase($urandom_range(NUM_PAGES, 1), $urandom_range(NUM_FRAMES, 1), 65,
                idle_mode_t'($urandom_range(3, 0)));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d references under %0d register settings with mixed idle and stall",
             refs_sent, settings_used);
    $display("seen %0d faults, %0d evictions, %0d write-backs, %0d invalid references",
             faults, evictions, writebacks, invalids);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
